// ===== hw/rtl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared sizes, register indexes, types and the reciprocal table of the
// Gaussian RBF kernel entry block.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int NUM_VECTORS = 64;
    localparam int VECTOR_LEN  = 256;

    localparam int VEC_W   = $clog2(NUM_VECTORS);
    localparam int IDX_W   = $clog2(VECTOR_LEN);
    localparam int ADDR_W  = VEC_W + IDX_W;
    localparam int LEN_W   = IDX_W + 1;
    localparam int ELEM_W  = 16;
    localparam int SQ_W    = 32;
    localparam int D2_W    = SQ_W + LEN_W;
    localparam int D2_LO_W = 20;
    localparam int D2_HI_W = D2_W - D2_LO_W;
    localparam int GAMMA_W = 24;
    localparam int P_W     = D2_W + GAMMA_W;
    localparam int KV_W    = 16;

    // exp(-x) is zero in Q1.15 beyond x = 12
    localparam logic [P_W-1:0] EXP_LIMIT = P_W'(12) << 40;

    localparam logic [1:0] REG_GAMMA = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } rbf_rd_req_t;

    // floor(2^32 / k) for the series divisors
    function automatic logic [32:0] rbf_recip(input logic [4:0] k);
        logic [32:0] r;
        case (k)
            5'd1:    r = 33'h1_0000_0000;
            5'd2:    r = 33'h0_8000_0000;
            5'd3:    r = 33'h0_5555_5555;
            5'd4:    r = 33'h0_4000_0000;
            5'd5:    r = 33'h0_3333_3333;
            5'd6:    r = 33'h0_2AAA_AAAA;
            5'd7:    r = 33'h0_2492_4924;
            5'd8:    r = 33'h0_2000_0000;
            5'd9:    r = 33'h0_1C71_C71C;
            5'd10:   r = 33'h0_1999_9999;
            5'd11:   r = 33'h0_1745_D174;
            5'd12:   r = 33'h0_1555_5555;
            5'd13:   r = 33'h0_13B1_3B13;
            5'd14:   r = 33'h0_1249_2492;
            5'd15:   r = 33'h0_1111_1111;
            5'd16:   r = 33'h0_1000_0000;
            default: r = 33'h1_0000_0000;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/rbf_store.sv =====
// ----------------------------------------------------------------------------
// rbf_store
// Vector element memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rbf_store
(
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [rbf_pkg::ADDR_W-1:0]             wr_addr,
    input  logic signed [rbf_pkg::ELEM_W-1:0]      wr_data,
    input  rbf_pkg::rbf_rd_req_t                   rd_req,
    output logic signed [rbf_pkg::ELEM_W-1:0]      rd_data_a,
    output logic signed [rbf_pkg::ELEM_W-1:0]      rd_data_b
);
    import rbf_pkg::*;

    logic signed [ELEM_W-1:0] mem [NUM_VECTORS*VECTOR_LEN];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.en)
        begin
            rd_data_a <= mem[rd_req.addr_a];
            rd_data_b <= mem[rd_req.addr_b];
        end
    end

endmodule

// ===== hw/rtl/rbf_exp.sv =====
// ----------------------------------------------------------------------------
// rbf_exp
// Iterative exp(-p) unit: 17-term Taylor series of exp(-p/16) in Q.30,
// then four squarings and rounding to Q1.15.
// ----------------------------------------------------------------------------
module rbf_exp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [rbf_pkg::P_W-1:0]       p,
    output logic                          done,
    output logic [rbf_pkg::KV_W-1:0]      value
);
    import rbf_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE, E_MUL_LO, E_MUL_HI, E_DIV_MUL, E_DIV_FIX, E_CLAMP, E_SQ, E_ROUND
    } exp_state_t;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    exp_state_t         state_reg, state_next;
    logic [29:0]        y_reg, y_next;
    logic [30:0]        term_reg, term_next;
    logic signed [33:0] s_reg, s_next;
    logic [4:0]         k_reg, k_next;
    logic [45:0]        prod_lo_reg, prod_lo_next;
    logic [30:0]        x_reg, x_next;
    logic [30:0]        q_reg, q_next;
    logic [30:0]        e_reg, e_next;
    logic [1:0]         sq_cnt_reg, sq_cnt_next;
    logic               done_reg, done_next;
    logic [KV_W-1:0]    value_reg, value_next;

    logic [45:0] prod_hi;
    logic [60:0] prod_sum;
    logic [63:0] recip_prod;
    logic [35:0] qk;
    logic [35:0] rem;
    logic [30:0] q_fix;
    logic [61:0] e_sq;
    logic [31:0] e_sq_rnd;
    logic [31:0] e_rnd;

    always_comb
    begin
        prod_hi    = term_reg * y_reg[29:15];
        prod_sum   = {prod_hi, 15'd0} + 61'(prod_lo_reg);
        recip_prod = 64'(x_reg) * 64'(rbf_recip(k_reg));
        qk         = 36'(q_reg) * 36'(k_reg);
        rem        = 36'(x_reg) - qk;
        q_fix      = (rem >= 36'(k_reg)) ? q_reg + 31'd1 : q_reg;
        e_sq       = 62'(e_reg) * 62'(e_reg);
        e_sq_rnd   = 32'((e_sq + 62'h2000_0000) >> 30);
        e_rnd      = 32'(e_reg) + 32'h4000;

        state_next   = state_reg;
        y_next       = y_reg;
        term_next    = term_reg;
        s_next       = s_reg;
        k_next       = k_reg;
        prod_lo_next = prod_lo_reg;
        x_next       = x_reg;
        q_next       = q_reg;
        e_next       = e_reg;
        sq_cnt_next  = sq_cnt_reg;
        done_next    = 1'b0;
        value_next   = value_reg;

        case (state_reg)
            E_IDLE:
            begin
                if (go)
                begin
                    if (p >= EXP_LIMIT)
                    begin
                        done_next  = 1'b1;
                        value_next = '0;
                    end
                    else
                    begin
                        y_next     = p[43:14];
                        term_next  = ONE_Q30;
                        s_next     = 34'(ONE_Q30);
                        k_next     = 5'd1;
                        state_next = E_MUL_LO;
                    end
                end
            end
            E_MUL_LO:
            begin
                prod_lo_next = term_reg * y_reg[14:0];
                state_next   = E_MUL_HI;
            end
            E_MUL_HI:
            begin
                x_next     = prod_sum[60:30];
                state_next = E_DIV_MUL;
            end
            E_DIV_MUL:
            begin
                q_next     = recip_prod[62:32];
                state_next = E_DIV_FIX;
            end
            E_DIV_FIX:
            begin
                term_next = q_fix;
                if (k_reg[0])
                begin
                    s_next = s_reg - $signed(34'(q_fix));
                end
                else
                begin
                    s_next = s_reg + $signed(34'(q_fix));
                end
                k_next     = k_reg + 5'd1;
                state_next = (k_reg == 5'd16) ? E_CLAMP : E_MUL_LO;
            end
            E_CLAMP:
            begin
                if (s_reg < 0)
                begin
                    e_next = '0;
                end
                else if (s_reg > $signed(34'(ONE_Q30)))
                begin
                    e_next = ONE_Q30;
                end
                else
                begin
                    e_next = s_reg[30:0];
                end
                sq_cnt_next = 2'd0;
                state_next  = E_SQ;
            end
            E_SQ:
            begin
                e_next      = e_sq_rnd[30:0];
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd3)
                begin
                    state_next = E_ROUND;
                end
            end
            E_ROUND:
            begin
                value_next = (e_rnd[31:15] > 17'd32768) ? 16'd32768 : e_rnd[30:15];
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_IDLE;
            y_reg       <= '0;
            term_reg    <= '0;
            s_reg       <= '0;
            k_reg       <= '0;
            prod_lo_reg <= '0;
            x_reg       <= '0;
            q_reg       <= '0;
            e_reg       <= '0;
            sq_cnt_reg  <= '0;
            done_reg    <= 1'b0;
            value_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            y_reg       <= y_next;
            term_reg    <= term_next;
            s_reg       <= s_next;
            k_reg       <= k_next;
            prod_lo_reg <= prod_lo_next;
            x_reg       <= x_next;
            q_reg       <= q_next;
            e_reg       <= e_next;
            sq_cnt_reg  <= sq_cnt_next;
            done_reg    <= done_next;
            value_reg   <= value_next;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

// ===== hw/rtl/rbf_kernel_matrix_entry.sv =====
// ----------------------------------------------------------------------------
// rbf_kernel_matrix_entry
// Gaussian RBF kernel entry exp(-gamma*|a-b|^2) over a store of vectors.
// ----------------------------------------------------------------------------
// A write beat (req_type 0) stores one element and leaves busy low. A
// compute beat (req_type 1) raises busy and reads len element pairs (len =
// active length, at most 256). One element pair is read from the dual-read
// vector memory per cycle and squared-accumulated, then the read and square
// pipeline drains into the accumulator. The 41x24 gamma product is formed as
// a high and a low partial product that are summed, and the iterative exp
// unit follows. When the product lies beyond the range of exp, the exp unit
// returns zero without the series. The result is shown for one cycle on
// result_valid and cannot be held off; it appears in the first cycle that
// busy is low. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rbf_kernel_matrix_entry
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic [5:0]                         row_vector,
    input  logic [7:0]                         element_index,
    input  logic signed [15:0]                 element_value,
    input  logic [5:0]                         col_vector,
    output logic                               result_valid,
    output logic [rbf_pkg::KV_W-1:0]           kernel_value,
    output logic [5:0]                         out_row,
    output logic [5:0]                         out_col,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [23:0]                        cfg_data
);
    import rbf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIST, S_GMUL_HI, S_GMUL_LO, S_GSUM, S_EXP
    } top_state_t;

    top_state_t          state_reg, state_next;
    logic [GAMMA_W-1:0]  gamma_reg, gamma_next;
    logic [8:0]          alen_reg, alen_next;
    logic [5:0]          row_reg, row_next;
    logic [5:0]          col_reg, col_next;
    logic                row_ok_reg, row_ok_next;
    logic                col_ok_reg, col_ok_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    issue_reg, issue_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                sq_valid_reg, sq_valid_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [D2_W-1:0]     d2_reg, d2_next;
    logic [D2_HI_W+GAMMA_W-1:0] pp_hi_reg, pp_hi_next;
    logic [D2_LO_W+GAMMA_W-1:0] pp_lo_reg, pp_lo_next;
    logic                res_valid_reg, res_valid_next;
    logic [KV_W-1:0]     kv_reg, kv_next;

    logic                      accept;
    logic                      wr_en;
    rbf_rd_req_t               rd_req;
    logic signed [ELEM_W-1:0]  rd_a, rd_b;
    logic signed [ELEM_W-1:0]  elem_a, elem_b;
    logic signed [ELEM_W:0]    diff;
    logic signed [2*ELEM_W+1:0] diff_sq;
    logic                      exp_go;
    logic [P_W-1:0]            p_sum;
    logic                      exp_done;
    logic [KV_W-1:0]           exp_value;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign wr_en     = accept && !req_type && (32'(row_vector) < NUM_VECTORS)
                       && (32'(element_index) < VECTOR_LEN);

    rbf_store u_store
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   ({row_vector[VEC_W-1:0], element_index[IDX_W-1:0]}),
        .wr_data   (element_value),
        .rd_req    (rd_req),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    rbf_exp u_exp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (exp_go),
        .p     (p_sum),
        .done  (exp_done),
        .value (exp_value)
    );

    always_comb
    begin
        rd_req.en     = (state_reg == S_DIST) && (issue_reg < len_reg);
        rd_req.addr_a = {row_reg[VEC_W-1:0], issue_reg[IDX_W-1:0]};
        rd_req.addr_b = {col_reg[VEC_W-1:0], issue_reg[IDX_W-1:0]};

        // a vector outside the store reads as zeros
        elem_a  = row_ok_reg ? rd_a : '0;
        elem_b  = col_ok_reg ? rd_b : '0;
        diff    = (ELEM_W+1)'(elem_a) - (ELEM_W+1)'(elem_b);
        diff_sq = diff * diff;
        p_sum   = {pp_hi_reg, {D2_LO_W{1'b0}}} + P_W'(pp_lo_reg);
        exp_go  = (state_reg == S_GSUM);

        state_next     = state_reg;
        gamma_next     = gamma_reg;
        alen_next      = alen_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        row_ok_next    = row_ok_reg;
        col_ok_next    = col_ok_reg;
        len_next       = len_reg;
        issue_next     = issue_reg;
        rd_pend_next   = rd_req.en;
        sq_valid_next  = rd_pend_reg;
        sq_next        = diff_sq[SQ_W-1:0];
        d2_next        = sq_valid_reg ? d2_reg + D2_W'(sq_reg) : d2_reg;
        pp_hi_next     = pp_hi_reg;
        pp_lo_next     = pp_lo_reg;
        res_valid_next = 1'b0;
        kv_next        = kv_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_GAMMA)
            begin
                gamma_next = cfg_data;
            end
            else if (cfg_index == REG_LEN)
            begin
                alen_next = cfg_data[8:0];
            end
        end

        if (rd_req.en)
        begin
            issue_next = issue_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type)
                begin
                    row_next    = row_vector;
                    col_next    = col_vector;
                    row_ok_next = 32'(row_vector) < NUM_VECTORS;
                    col_ok_next = 32'(col_vector) < NUM_VECTORS;
                    len_next    = (32'(alen_reg) > VECTOR_LEN) ? LEN_W'(VECTOR_LEN)
                                                               : LEN_W'(alen_reg);
                    issue_next  = '0;
                    d2_next     = '0;
                    state_next  = S_DIST;
                end
            end
            S_DIST:
            begin
                if (!rd_req.en && !rd_pend_reg && !sq_valid_reg)
                begin
                    state_next = S_GMUL_HI;
                end
            end
            S_GMUL_HI:
            begin
                pp_hi_next = d2_reg[D2_W-1:D2_LO_W] * gamma_reg;
                state_next = S_GMUL_LO;
            end
            S_GMUL_LO:
            begin
                pp_lo_next = d2_reg[D2_LO_W-1:0] * gamma_reg;
                state_next = S_GSUM;
            end
            S_GSUM:
            begin
                state_next = S_EXP;
            end
            S_EXP:
            begin
                if (exp_done)
                begin
                    kv_next        = exp_value;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gamma_reg     <= '0;
            alen_reg      <= 9'd256;
            row_reg       <= '0;
            col_reg       <= '0;
            row_ok_reg    <= 1'b0;
            col_ok_reg    <= 1'b0;
            len_reg       <= '0;
            issue_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sq_reg        <= '0;
            d2_reg        <= '0;
            pp_hi_reg     <= '0;
            pp_lo_reg     <= '0;
            res_valid_reg <= 1'b0;
            kv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gamma_reg     <= gamma_next;
            alen_reg      <= alen_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            row_ok_reg    <= row_ok_next;
            col_ok_reg    <= col_ok_next;
            len_reg       <= len_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_pend_next;
            sq_valid_reg  <= sq_valid_next;
            sq_reg        <= sq_next;
            d2_reg        <= d2_next;
            pp_hi_reg     <= pp_hi_next;
            pp_lo_reg     <= pp_lo_next;
            res_valid_reg <= res_valid_next;
            kv_reg        <= kv_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign kernel_value = kv_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;

    a_result_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a compute in flight");

    a_compute_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type) |=> busy)
        else $error("compute beat did not raise busy");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |=> (!busy && !result_valid))
        else $error("write beat started a compute");

endmodule
